// ===== rtl/core/ipv4_header_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// ipv4_header_parser_top_defines.svh
// Assertion macros shared by the IPv4 header parser RTL.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_PARSER_TOP_DEFINES_SVH
`define IPV4_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define IPH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define IPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/iph_pkg.sv =====
// ----------------------------------------------------------------------------
// iph_pkg
// Types and constants of the IPv4 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package iph_pkg;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
  localparam logic [2:0] ST_BAD_VER_IHL = 3'd2;
  localparam logic [2:0] ST_TRUNC_HDR   = 3'd3;
  localparam logic [2:0] ST_BAD_TOT_LEN = 3'd4;

  localparam logic [15:0] MIN_PKT_BYTES  = 16'd20;
  localparam logic [15:0] BYTE_INDEX_MAX = 16'hFFFF;
  localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
  localparam logic [3:0]  IPV4_VERSION   = 4'd4;
  localparam logic [3:0]  MIN_IHL        = 4'd5;

  // header byte positions that load a field
  localparam logic [15:0] POS_VER_IHL  = 16'd0;
  localparam logic [15:0] POS_TOS      = 16'd1;
  localparam logic [15:0] POS_LEN_HI   = 16'd2;
  localparam logic [15:0] POS_LEN_LO   = 16'd3;
  localparam logic [15:0] POS_ID_HI    = 16'd4;
  localparam logic [15:0] POS_ID_LO    = 16'd5;
  localparam logic [15:0] POS_FRAG_HI  = 16'd6;
  localparam logic [15:0] POS_FRAG_LO  = 16'd7;
  localparam logic [15:0] POS_TTL      = 16'd8;
  localparam logic [15:0] POS_PROTO    = 16'd9;
  localparam logic [15:0] POS_SRC_0    = 16'd12;
  localparam logic [15:0] POS_SRC_1    = 16'd13;
  localparam logic [15:0] POS_SRC_2    = 16'd14;
  localparam logic [15:0] POS_SRC_3    = 16'd15;
  localparam logic [15:0] POS_DST_0    = 16'd16;
  localparam logic [15:0] POS_DST_1    = 16'd17;
  localparam logic [15:0] POS_DST_2    = 16'd18;
  localparam logic [15:0] POS_DST_3    = 16'd19;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  header_words;
    logic [7:0]  service_type;
    logic [15:0] total_length;
    logic [15:0] ident_value;
    logic [2:0]  frag_flags;
    logic [12:0] frag_offset;
    logic [7:0]  hop_limit;
    logic [7:0]  proto_number;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic        checksum_good;
  } iph_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/iph_if.sv =====
// ----------------------------------------------------------------------------
// iph_if
// Byte input channel and result channel of the IPv4 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface iph_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface iph_result_if;
  logic                valid;
  logic                ready;
  iph_pkg::iph_result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ipv4_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_parser_top
// Streams an IPv4 packet byte by byte, captures the fixed header fields,
// checks the header checksum and reports one result per packet.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          handshake
//  in_bus    in   data_byte, last_byte             valid/ready
//  out_bus   out  iph_result_t (status, fields)    valid/ready
//
//  One byte per cycle. A byte is registered in the input register, then
//  updates count, checksum and fields; the final byte loads the result
//  register and sets its valid bit as it leaves the input register.
//  Reset (rst_n low, synchronous) clears the valid bits, byte count and sum.
//  With the result stalled, bytes keep flowing; a final byte waits in the
//  input register and in_bus.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipv4_header_parser_top_defines.svh"

module ipv4_header_parser_top (
  input  wire           clk,
  input  wire           rst_n,
  iph_byte_if.sink      in_bus,
  iph_result_if.source  out_bus
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // packet state
  logic [15:0] byte_index_r, byte_index_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  vihl_r, vihl_nxt;
  logic [7:0]  tos_r, tos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  iph_pkg::iph_result_t result_r, result_nxt;

  logic        out_free, s1_fire;
  logic [3:0]  ihl_cur;
  logic [5:0]  hdr_len_cur, hdr_len_fin;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;
  logic [15:0] size, eff;
  logic [2:0]  status;

  assign out_free     = !out_valid_r || out_bus.ready;
  assign s1_fire      = s1_valid_r && (!s1_last_r || out_free);
  assign in_bus.ready = !s1_valid_r || s1_fire;
  assign s1_valid_nxt = in_bus.ready ? in_bus.valid : s1_valid_r;

  // field capture by byte position
  always_comb begin
    vihl_nxt  = vihl_r;
    tos_nxt   = tos_r;
    len_nxt   = len_r;
    ident_nxt = ident_r;
    frag_nxt  = frag_r;
    ttl_nxt   = ttl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    unique case (byte_index_r) inside
      iph_pkg::POS_VER_IHL: vihl_nxt = s1_byte_r;
      iph_pkg::POS_TOS:     tos_nxt = s1_byte_r;
      iph_pkg::POS_LEN_HI:  len_nxt = {s1_byte_r, len_r[7:0]};
      iph_pkg::POS_LEN_LO:  len_nxt = {len_r[15:8], s1_byte_r};
      iph_pkg::POS_ID_HI:   ident_nxt = {s1_byte_r, ident_r[7:0]};
      iph_pkg::POS_ID_LO:   ident_nxt = {ident_r[15:8], s1_byte_r};
      iph_pkg::POS_FRAG_HI: frag_nxt = {s1_byte_r, frag_r[7:0]};
      iph_pkg::POS_FRAG_LO: frag_nxt = {frag_r[15:8], s1_byte_r};
      iph_pkg::POS_TTL:     ttl_nxt = s1_byte_r;
      iph_pkg::POS_PROTO:   proto_nxt = s1_byte_r;
      iph_pkg::POS_SRC_0, iph_pkg::POS_SRC_1,
      iph_pkg::POS_SRC_2, iph_pkg::POS_SRC_3: src_nxt = {src_r[23:0], s1_byte_r};
      iph_pkg::POS_DST_0, iph_pkg::POS_DST_1,
      iph_pkg::POS_DST_2, iph_pkg::POS_DST_3: dst_nxt = {dst_r[23:0], s1_byte_r};
      default: ;
    endcase
  end

  // checksum over the header bytes; the first byte sets ihl for itself
  assign ihl_cur     = vihl_nxt[3:0];
  assign hdr_len_cur = {ihl_cur, 2'b00};
  assign sum_wide    = {1'b0, sum_r} + {1'b0, pend_r, s1_byte_r};
  assign sum_fold    = sum_wide[15:0] + {15'd0, sum_wide[16]};

  always_comb begin
    pend_nxt = pend_r;
    sum_nxt  = sum_r;
    if (byte_index_r < {10'd0, hdr_len_cur}) begin
      if (!byte_index_r[0]) begin
        pend_nxt = s1_byte_r;
      end else begin
        sum_nxt = sum_fold;
      end
    end
  end

  // packet size including this byte, saturating
  assign size = (byte_index_r == iph_pkg::BYTE_INDEX_MAX) ? byte_index_r
                                                          : byte_index_r + 16'd1;
  assign byte_index_nxt = size;

  assign hdr_len_fin = {vihl_nxt[3:0], 2'b00};
  assign eff = (size < len_nxt) ? size : len_nxt;

  always_comb begin
    if (size < iph_pkg::MIN_PKT_BYTES) begin
      status = iph_pkg::ST_TOO_SHORT;
    end else if (vihl_nxt[7:4] != iph_pkg::IPV4_VERSION || vihl_nxt[3:0] < iph_pkg::MIN_IHL) begin
      status = iph_pkg::ST_BAD_VER_IHL;
    end else if (size < {10'd0, hdr_len_fin}) begin
      status = iph_pkg::ST_TRUNC_HDR;
    end else if (eff < {10'd0, hdr_len_fin}) begin
      status = iph_pkg::ST_BAD_TOT_LEN;
    end else begin
      status = iph_pkg::ST_OK;
    end
  end

  always_comb begin
    result_nxt = '0;
    result_nxt.status = status;
    if (status != iph_pkg::ST_TOO_SHORT && status != iph_pkg::ST_BAD_VER_IHL) begin
      result_nxt.header_words  = vihl_nxt[3:0];
      result_nxt.service_type  = tos_nxt;
      result_nxt.total_length  = len_nxt;
      result_nxt.ident_value   = ident_nxt;
      result_nxt.frag_flags    = frag_nxt[15:13];
      result_nxt.frag_offset   = frag_nxt[12:0];
      result_nxt.hop_limit     = ttl_nxt;
      result_nxt.proto_number  = proto_nxt;
      result_nxt.source_addr   = src_nxt;
      result_nxt.dest_addr     = dst_nxt;
      result_nxt.checksum_good = (status != iph_pkg::ST_TRUNC_HDR) &&
                                 (sum_nxt == iph_pkg::SUM_GOOD);
    end
  end

  always_comb begin
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      byte_index_r <= '0;
      sum_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        byte_index_r <= s1_last_r ? 16'd0 : byte_index_nxt;
        sum_r        <= s1_last_r ? 16'd0 : sum_nxt;
      end
    end
  end

  // payload; every header field is rewritten before a packet can use it
  always_ff @(posedge clk) begin
    if (in_bus.ready) begin
      s1_byte_r <= in_bus.data_byte;
      s1_last_r <= in_bus.last_byte;
    end
    if (s1_fire) begin
      pend_r  <= pend_nxt;
      vihl_r  <= vihl_nxt;
      tos_r   <= tos_nxt;
      len_r   <= len_nxt;
      ident_r <= ident_nxt;
      frag_r  <= frag_nxt;
      ttl_r   <= ttl_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
    if (s1_fire && s1_last_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.result = result_r;

  `IPH_ASSERT_NOW(a_stall_only_on_final, !in_bus.ready,
                  s1_valid_r && s1_last_r && out_valid_r,
                  "input stalled without a final byte waiting on a busy result")
  `IPH_ASSERT_NEXT(a_final_restarts, s1_fire && s1_last_r,
                   out_valid_r && byte_index_r == 16'd0 && sum_r == 16'd0,
                   "final byte did not post a result and restart the count")
  `IPH_ASSERT_NEXT(a_no_spurious_result, s1_fire && !s1_last_r && !out_valid_r,
                   !out_valid_r, "result appeared without a final byte")
  `IPH_ASSERT_NOW(a_reject_zero_fields,
                  out_valid_r && (result_r.status == iph_pkg::ST_TOO_SHORT ||
                                  result_r.status == iph_pkg::ST_BAD_VER_IHL),
                  !result_r.checksum_good && result_r.header_words == 4'd0 &&
                  result_r.source_addr == 32'd0,
                  "rejected packet reports nonzero fields")
  `IPH_ASSERT_NOW(a_trunc_no_checksum,
                  out_valid_r && result_r.status == iph_pkg::ST_TRUNC_HDR,
                  !result_r.checksum_good, "truncated header flagged checksum good")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for ipv4_header_parser_top. Packets are streamed one byte per
// word into the input channel with random gaps and output back-pressure. A
// byte-level model of the parser predicts the result for every final byte.
// Each result taken from the output channel is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  logic clk;
  logic rst_n;

  iph_byte_if   in_bus ();
  iph_result_if out_bus ();

  ipv4_header_parser_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  pkt_byte_t            wire_bytes[$];
  iph_pkg::iph_result_t predicted_hdrs[$];

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  hold_reqs = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  err_count = 0;
  int  cycle_count = 0;
  int  in_accept_cnt = 0;
  int  in_accept_seen = 0;

  // parser state mirror
  logic [15:0] cap_count;
  logic [16:0] cap_sum;
  logic [7:0]  cap_high;
  logic [7:0]  cap_ver_ihl;
  logic [7:0]  cap_tos;
  logic [15:0] cap_len;
  logic [15:0] cap_ident;
  logic [15:0] cap_frag;
  logic [7:0]  cap_ttl;
  logic [7:0]  cap_proto;
  logic [31:0] cap_src;
  logic [31:0] cap_dst;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic clear_capture();
    cap_count   = '0;
    cap_sum     = '0;
    cap_high    = '0;
    cap_ver_ihl = '0;
    cap_tos     = '0;
    cap_len     = '0;
    cap_ident   = '0;
    cap_frag    = '0;
    cap_ttl     = '0;
    cap_proto   = '0;
    cap_src     = '0;
    cap_dst     = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    iph_pkg::iph_result_t res;
    logic [15:0] pos;
    logic [15:0] hdr_len;
    logic [15:0] eff;
    logic [16:0] s;
    logic [3:0]  ihl;
    pos = cap_count;
    case (pos) inside
      iph_pkg::POS_VER_IHL: cap_ver_ihl = b;
      iph_pkg::POS_TOS:     cap_tos = b;
      iph_pkg::POS_LEN_HI:  cap_len[15:8] = b;
      iph_pkg::POS_LEN_LO:  cap_len[7:0] = b;
      iph_pkg::POS_ID_HI:   cap_ident[15:8] = b;
      iph_pkg::POS_ID_LO:   cap_ident[7:0] = b;
      iph_pkg::POS_FRAG_HI: cap_frag[15:8] = b;
      iph_pkg::POS_FRAG_LO: cap_frag[7:0] = b;
      iph_pkg::POS_TTL:     cap_ttl = b;
      iph_pkg::POS_PROTO:   cap_proto = b;
      iph_pkg::POS_SRC_0, iph_pkg::POS_SRC_1,
      iph_pkg::POS_SRC_2, iph_pkg::POS_SRC_3: cap_src = {cap_src[23:0], b};
      iph_pkg::POS_DST_0, iph_pkg::POS_DST_1,
      iph_pkg::POS_DST_2, iph_pkg::POS_DST_3: cap_dst = {cap_dst[23:0], b};
      default: ;
    endcase
    ihl = cap_ver_ihl[3:0];
    hdr_len = {10'd0, ihl, 2'b00};
    if (pos < hdr_len) begin
      if (!pos[0]) begin
        cap_high = b;
      end else begin
        s = cap_sum + {1'b0, cap_high, b};
        if (s[16]) s = {1'b0, s[15:0]} + 17'd1;   // end-around carry
        cap_sum = s;
      end
    end
    if (cap_count != iph_pkg::BYTE_INDEX_MAX) cap_count = cap_count + 16'd1;
    if (last) begin
      res = '0;
      if (cap_count < iph_pkg::MIN_PKT_BYTES) begin
        res.status = iph_pkg::ST_TOO_SHORT;
      end else if (cap_ver_ihl[7:4] != iph_pkg::IPV4_VERSION || ihl < iph_pkg::MIN_IHL) begin
        res.status = iph_pkg::ST_BAD_VER_IHL;
      end else if (cap_count < hdr_len) begin
        res.status = iph_pkg::ST_TRUNC_HDR;
      end else begin
        eff = (cap_count < cap_len) ? cap_count : cap_len;
        res.status = (eff < hdr_len) ? iph_pkg::ST_BAD_TOT_LEN : iph_pkg::ST_OK;
      end
      if (res.status != iph_pkg::ST_TOO_SHORT && res.status != iph_pkg::ST_BAD_VER_IHL) begin
        res.header_words  = ihl;
        res.service_type  = cap_tos;
        res.total_length  = cap_len;
        res.ident_value   = cap_ident;
        res.frag_flags    = cap_frag[15:13];
        res.frag_offset   = cap_frag[12:0];
        res.hop_limit     = cap_ttl;
        res.proto_number  = cap_proto;
        res.source_addr   = cap_src;
        res.dest_addr     = cap_dst;
        res.checksum_good = (res.status != iph_pkg::ST_TRUNC_HDR) &&
                            (cap_sum == {1'b0, iph_pkg::SUM_GOOD});
      end
      predicted_hdrs.insert(predicted_hdrs.size(), res);
      clear_capture();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    end
  endtask

  // Builds a packet of 'size' bytes; when the header is at least 20 bytes its
  // checksum is made valid unless csum_ok is clear, in which case it is corrupted.
  task automatic send_packet(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [7:0] tos, input logic [15:0] tlen,
                             input logic [15:0] idv, input logic [15:0] fragw,
                             input logic [7:0] ttl, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst,
                             input int size, input bit csum_ok);
    logic [7:0]  pkt[];
    logic [16:0] acc;
    logic [15:0] ck;
    pkt_byte_t   w;
    int          hdr;
    int          len;
    hdr = 4 * ihl;
    len = size;
    if (len < hdr) len = hdr;
    if (len < 20) len = 20;
    pkt = new[len];
    foreach (pkt[i]) pkt[i] = 8'($urandom());
    pkt[0]  = {ver, ihl};
    pkt[1]  = tos;
    pkt[2]  = tlen[15:8];
    pkt[3]  = tlen[7:0];
    pkt[4]  = idv[15:8];
    pkt[5]  = idv[7:0];
    pkt[6]  = fragw[15:8];
    pkt[7]  = fragw[7:0];
    pkt[8]  = ttl;
    pkt[9]  = proto;
    pkt[12] = src[31:24];
    pkt[13] = src[23:16];
    pkt[14] = src[15:8];
    pkt[15] = src[7:0];
    pkt[16] = dst[31:24];
    pkt[17] = dst[23:16];
    pkt[18] = dst[15:8];
    pkt[19] = dst[7:0];
    if (hdr >= 20) begin
      pkt[10] = 8'h00;
      pkt[11] = 8'h00;
      acc = '0;
      for (int i = 0; i < hdr; i += 2) begin
        acc = acc + {1'b0, pkt[i], pkt[i+1]};
        if (acc[16]) acc = {1'b0, acc[15:0]} + 17'd1;
      end
      ck = ~acc[15:0];
      if (!csum_ok) ck = ck ^ 16'($urandom_range(1, 65535));
      pkt[10] = ck[15:8];
      pkt[11] = ck[7:0];
    end
    for (int i = 0; i < size; i++) begin
      w.data = pkt[i];
      w.last = (i == size - 1);
      wire_bytes.insert(wire_bytes.size(), w);
    end
  endtask

  // Mostly well-formed packets with random content, plus broken ones and noise.
  task automatic rand_packet(output int nbytes);
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tlen;
    pkt_byte_t   w;
    int          hdr;
    int          size;
    int          kind;
    bit          csum_ok;
    kind = $urandom_range(99);
    ver = iph_pkg::IPV4_VERSION;
    ihl = ($urandom_range(99) < 70) ? iph_pkg::MIN_IHL : 4'($urandom_range(6, 15));
    hdr = 4 * ihl;
    size = hdr + $urandom_range(0, 16);
    csum_ok = 1'b1;
    tlen = 16'(size);
    if ($urandom_range(3) == 0) tlen = 16'($urandom());
    if (kind >= 93) begin
      size = $urandom_range(1, 40);
      for (int i = 0; i < size; i++) begin
        w.data = 8'($urandom());
        w.last = (i == size - 1);
        wire_bytes.insert(wire_bytes.size(), w);
      end
      nbytes = size;
      return;
    end
    if (kind >= 66 && kind < 73) begin
      csum_ok = 1'b0;
    end else if (kind >= 73 && kind < 78) begin
      tlen = 16'($urandom_range(0, hdr - 1));
    end else if (kind >= 78 && kind < 83) begin
      ihl = 4'($urandom_range(6, 15));
      size = $urandom_range(20, 4 * ihl - 1);
    end else if (kind >= 83 && kind < 88) begin
      size = $urandom_range(1, 19);
    end else if (kind >= 88) begin
      if ($urandom_range(1)) begin
        do ver = 4'($urandom()); while (ver == iph_pkg::IPV4_VERSION);
      end else begin
        ihl = 4'($urandom_range(0, 4));
      end
      size = $urandom_range(20, 40);
    end
    send_packet(ver, ihl, 8'($urandom()), tlen, 16'($urandom()), 16'($urandom()),
                8'($urandom()), 8'($urandom()), $urandom(), $urandom(), size, csum_ok);
    nbytes = size;
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    int pkts;
    int bytes;
    int n;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    pkts = 0;
    bytes = 0;
    while (bytes < 75 || pkts < 3) begin
      rand_packet(n);
      bytes += n;
      pkts++;
    end
    while (wire_bytes.size() != 0) @(posedge clk);
  endtask

  // byte driver
  always @(negedge clk) begin
    pkt_byte_t w;
    bit        taken;
    taken = (in_accept_cnt != in_accept_seen);
    in_accept_seen = in_accept_cnt;
    if (!rst_n) begin
      in_bus.valid     <= 1'b0;
      in_bus.data_byte <= 8'h00;
      in_bus.last_byte <= 1'b0;
    end else if (!in_bus.valid || taken) begin
      if (wire_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        w = wire_bytes.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= w.data;
        in_bus.last_byte <= w.last;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver; a requested hold-off keeps ready low for a long stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_seen + 1;
      hold_left <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // input tracking and result checking
  always @(posedge clk) begin
    iph_pkg::iph_result_t exp_r;
    iph_pkg::iph_result_t act_r;
    if (!rst_n) begin
      clear_capture();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        act_r = out_bus.result;
        if (predicted_hdrs.size() == 0) begin
          err_count++;
          $error("result word with no prediction pending: 0x%0h", act_r);
        end else begin
          exp_r = predicted_hdrs.pop_front();
          check_field("status", 32'(exp_r.status), 32'(act_r.status));
          check_field("header_words", 32'(exp_r.header_words), 32'(act_r.header_words));
          check_field("service_type", 32'(exp_r.service_type), 32'(act_r.service_type));
          check_field("total_length", 32'(exp_r.total_length), 32'(act_r.total_length));
          check_field("ident_value", 32'(exp_r.ident_value), 32'(act_r.ident_value));
          check_field("frag_flags", 32'(exp_r.frag_flags), 32'(act_r.frag_flags));
          check_field("frag_offset", 32'(exp_r.frag_offset), 32'(act_r.frag_offset));
          check_field("hop_limit", 32'(exp_r.hop_limit), 32'(act_r.hop_limit));
          check_field("proto_number", 32'(exp_r.proto_number), 32'(act_r.proto_number));
          check_field("source_addr", exp_r.source_addr, act_r.source_addr);
          check_field("dest_addr", exp_r.dest_addr, act_r.dest_addr);
          check_field("checksum_good", 32'(exp_r.checksum_good),
                      32'(act_r.checksum_good));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        in_accept_cnt++;
        parse_byte(in_bus.data_byte, in_bus.last_byte);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed packets, no idling
    send_packet(4'd4, 4'd5, 8'h00, 16'd20, 16'h0000, 16'h0000, 8'h00, 8'h00,
                32'h0, 32'h0, 20, 1'b1);
    send_packet(4'd4, 4'd5, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 20, 1'b1);
    send_packet(4'd4, 4'd15, 8'h2E, 16'd70, 16'h1234, 16'h4000, 8'd64, 8'd6,
                32'hC0A8_0001, 32'h0A00_0001, 70, 1'b1);
    send_packet(4'd4, 4'd5, 8'h10, 16'd40, 16'hBEEF, 16'h2005, 8'd1, 8'd17,
                32'h0102_0304, 32'hFEDC_BA98, 40, 1'b1);
    // bad checksum
    send_packet(4'd4, 4'd5, 8'h00, 16'd28, 16'h5555, 16'h0000, 8'd128, 8'd1,
                32'hAAAA_5555, 32'h5555_AAAA, 28, 1'b0);
    // too short
    send_packet(4'd4, 4'd5, 8'h00, 16'd20, 16'h0, 16'h0, 8'h0, 8'h0,
                32'h0, 32'h0, 1, 1'b1);
    send_packet(4'd4, 4'd5, 8'h00, 16'd20, 16'h0, 16'h0, 8'h0, 8'h0,
                32'h0, 32'h0, 19, 1'b1);
    // bad version or header length
    send_packet(4'd6, 4'd5, 8'h00, 16'd20, 16'h1, 16'h0, 8'h40, 8'h6,
                32'h1, 32'h2, 20, 1'b1);
    send_packet(4'd4, 4'd4, 8'h00, 16'd20, 16'h1, 16'h0, 8'h40, 8'h6,
                32'h1, 32'h2, 20, 1'b1);
    send_packet(4'd0, 4'd0, 8'h00, 16'd0, 16'h0, 16'h0, 8'h0, 8'h0,
                32'h0, 32'h0, 24, 1'b1);
    send_packet(4'd15, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 20, 1'b1);
    // header longer than the packet
    send_packet(4'd4, 4'd15, 8'h01, 16'd60, 16'h7777, 16'h1FFF, 8'd3, 8'd50,
                32'h7F00_0001, 32'h7F00_0002, 30, 1'b1);
    // total length under the header length
    send_packet(4'd4, 4'd5, 8'h00, 16'd10, 16'h0101, 16'h0, 8'd9, 8'd9,
                32'h9, 32'h9, 24, 1'b1);
    send_packet(4'd4, 4'd6, 8'h00, 16'd0, 16'h0202, 16'h0, 8'd9, 8'd9,
                32'h9, 32'h9, 24, 1'b1);
    // total length beyond the bytes received
    send_packet(4'd4, 4'd5, 8'h00, 16'd1000, 16'h0303, 16'hE000, 8'd9, 8'd9,
                32'h9, 32'h9, 24, 1'b1);
    while (wire_bytes.size() != 0) @(posedge clk);

    // long output hold-off while bytes keep coming
    hold_reqs++;
    run_phase(0, 0);
    run_phase(76, 0);
    run_phase(0, 76);
    run_phase(37, 37);

    while (wire_bytes.size() != 0 || in_bus.valid || predicted_hdrs.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0 && predicted_hdrs.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
